### src/stwhp_pkg.sv
// ----------------------------------------------------------------------------
// stwhp_pkg: shared types and constants of the sleep timer
// Field widths, command codes, register indexes, state and item structures,
// and the preset table of the countdown.
// ----------------------------------------------------------------------------
package stwhp_pkg;

  localparam int TICKS_PER_SECOND = 100;
  localparam int TickW            = 7;
  localparam int FuncW            = 2;
  localparam int ModeW            = 2;
  localparam int TimerModeW       = 3;
  localparam int SecW             = 16;
  localparam int CountW           = 16;
  localparam int HeatW            = 8;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 16;
  localparam int NumPresets       = 6;

  localparam logic [ModeW-1:0] ModeProtected = ModeW'(2);
  localparam logic [ModeW-1:0] ModeOff       = ModeW'(0);

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_PRESET  = 2'd1,
    FUNC_SECONDS = 2'd2,
    FUNC_MODES   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMER_MODE   = 2'd0,
    REG_HEAT_DELAY   = 2'd1,
    REG_OVR_LIMIT    = 2'd2,
    REG_CORR_HEAT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TimerModeW-1:0] timer_mode;
    logic [CountW-1:0]     heat_delay_limit;
    logic [CountW-1:0]     overrange_limit;
    logic [HeatW-1:0]      corrected_heat_level;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             device_on;
    logic [SecW-1:0]  seconds_value;
    logic [ModeW-1:0] stay_mode_in;
    logic [ModeW-1:0] gap_mode_in;
    logic             heat_start_in;
    logic             clear_overrange;
  } in_item_t;

  typedef struct packed {
    logic             power_off;
    logic             overrange;
    logic [HeatW-1:0] heat_level;
    logic [SecW-1:0]  seconds_left;
    logic [ModeW-1:0] stay_mode_out;
    logic [ModeW-1:0] gap_mode_out;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_count;
    logic [SecW-1:0]   seconds_left;
    logic [CountW-1:0] protect_count;
    logic [CountW-1:0] heat_delay_count;
    logic              heat_armed;
    logic [ModeW-1:0]  stay_mode;
    logic [ModeW-1:0]  gap_mode;
    logic              overrange_flag;
    logic [HeatW-1:0]  heat_level;
  } state_t;

  // Countdown length in seconds for each timed preset; continuous mode loads zero.
  function automatic logic [SecW-1:0] preset_secs(input logic [TimerModeW-1:0] mode);
    logic [SecW-1:0] secs;
    unique case (mode)
      3'd1:    secs = SecW'(30 * 60);
      3'd2:    secs = SecW'(60 * 60);
      3'd3:    secs = SecW'(2 * 60 * 60);
      3'd4:    secs = SecW'(4 * 60 * 60);
      3'd5:    secs = SecW'(8 * 60 * 60);
      default: secs = '0;
    endcase
    return secs;
  endfunction

endpackage

### src/stwhp_in_if.sv
// ----------------------------------------------------------------------------
// stwhp_in_if: input channel of the sleep timer
// Valid/ready channel that carries one command or tick item.
// ----------------------------------------------------------------------------
interface stwhp_in_if;
  logic                          valid;
  logic                          ready;
  logic [stwhp_pkg::FuncW-1:0]   func;
  logic                          device_on;
  logic [stwhp_pkg::SecW-1:0]    seconds_value;
  logic [stwhp_pkg::ModeW-1:0]   stay_mode_in;
  logic [stwhp_pkg::ModeW-1:0]   gap_mode_in;
  logic                          heat_start_in;
  logic                          clear_overrange;

  modport source (
    output valid, func, device_on, seconds_value, stay_mode_in, gap_mode_in,
           heat_start_in, clear_overrange,
    input  ready
  );

  modport sink (
    input  valid, func, device_on, seconds_value, stay_mode_in, gap_mode_in,
           heat_start_in, clear_overrange,
    output ready
  );
endinterface

### src/stwhp_out_if.sv
// ----------------------------------------------------------------------------
// stwhp_out_if: result channel of the sleep timer
// Valid/ready channel that carries one status item per input item.
// ----------------------------------------------------------------------------
interface stwhp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          power_off;
  logic                          overrange;
  logic [stwhp_pkg::HeatW-1:0]   heat_level;
  logic [stwhp_pkg::SecW-1:0]    seconds_left;
  logic [stwhp_pkg::ModeW-1:0]   stay_mode_out;
  logic [stwhp_pkg::ModeW-1:0]   gap_mode_out;

  modport source (
    output valid, power_off, overrange, heat_level, seconds_left, stay_mode_out,
           gap_mode_out,
    input  ready
  );

  modport sink (
    input  valid, power_off, overrange, heat_level, seconds_left, stay_mode_out,
           gap_mode_out,
    output ready
  );
endinterface

### src/stwhp_cfg_regs.sv
// ----------------------------------------------------------------------------
// stwhp_cfg_regs: configuration registers
// Holds timer mode, heat delay, over-range limit and corrected heat value.
// ----------------------------------------------------------------------------
module stwhp_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stwhp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [stwhp_pkg::CfgDataW-1:0]    cfg_data_i,
  output stwhp_pkg::cfg_t                   cfg_o
);
  import stwhp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TIMER_MODE: cfg_d.timer_mode           = cfg_data_i[TimerModeW-1:0];
        REG_HEAT_DELAY: cfg_d.heat_delay_limit     = cfg_data_i[CountW-1:0];
        REG_OVR_LIMIT:  cfg_d.overrange_limit      = cfg_data_i[CountW-1:0];
        REG_CORR_HEAT:  cfg_d.corrected_heat_level = cfg_data_i[HeatW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

### src/stwhp_step.sv
// ----------------------------------------------------------------------------
// stwhp_step: next-state logic of the sleep timer
// Applies one item to the state: prescaler, loads, mode writes and the
// one-second step with heat delay, protection counting and countdown.
// ----------------------------------------------------------------------------
module stwhp_step (
  input  stwhp_pkg::state_t   st_i,
  input  stwhp_pkg::cfg_t     cfg_i,
  input  stwhp_pkg::in_item_t item_i,
  output stwhp_pkg::state_t   st_o,
  output logic                power_off_o
);
  import stwhp_pkg::*;

  logic [TickW-1:0]  tick_inc;
  logic              sec_step;
  logic [CountW-1:0] hd_inc;
  logic [CountW-1:0] pc_inc1, pc_inc2, pc1, pc2, gap_cand;
  logic              stay_tick, gap_tick, trip1, trip2;
  state_t            nxt;
  logic              off;

  assign tick_inc = st_i.tick_count + TickW'(1);
  assign hd_inc   = st_i.heat_delay_count + CountW'(1);
  assign pc_inc1  = st_i.protect_count + CountW'(1);
  assign pc_inc2  = st_i.protect_count + CountW'(2);

  // Stay-on protection counts first; the gap count then builds on its result,
  // so with both modes protected the counter gains two in one second.
  assign stay_tick = (st_i.stay_mode == ModeProtected);
  assign trip1     = stay_tick && (pc_inc1 > cfg_i.overrange_limit);
  assign pc1       = stay_tick ? (trip1 ? '0 : pc_inc1) : st_i.protect_count;

  assign gap_tick  = (st_i.gap_mode == ModeProtected);
  assign gap_cand  = trip1 ? CountW'(1) : (stay_tick ? pc_inc2 : pc_inc1);
  assign trip2     = gap_tick && (gap_cand > cfg_i.overrange_limit);
  assign pc2       = gap_tick ? (trip2 ? '0 : gap_cand) : pc1;

  always_comb begin
    nxt      = st_i;
    off      = 1'b0;
    sec_step = 1'b0;

    unique case (func_e'(item_i.func))
      FUNC_TICK: begin
        if (item_i.device_on) begin
          if (tick_inc >= TickW'(TICKS_PER_SECOND)) begin
            sec_step       = 1'b1;
            nxt.tick_count = '0;
          end else begin
            nxt.tick_count = tick_inc;
          end
        end
      end
      FUNC_PRESET: begin
        nxt.tick_count = '0;
        if (cfg_i.timer_mode < TimerModeW'(NumPresets)) begin
          nxt.seconds_left  = preset_secs(cfg_i.timer_mode);
          nxt.protect_count = '0;
        end
      end
      FUNC_SECONDS: begin
        nxt.seconds_left = item_i.seconds_value;
        nxt.tick_count   = '0;
      end
      FUNC_MODES: begin
        nxt.stay_mode = item_i.stay_mode_in;
        nxt.gap_mode  = item_i.gap_mode_in;
        if (item_i.heat_start_in) begin
          nxt.heat_armed = 1'b1;
        end
        if (item_i.clear_overrange) begin
          nxt.overrange_flag = 1'b0;
        end
      end
      default: nxt = st_i;
    endcase

    if (sec_step) begin
      if (st_i.heat_armed) begin
        if (hd_inc > cfg_i.heat_delay_limit) begin
          nxt.heat_armed       = 1'b0;
          nxt.heat_delay_count = '0;
          nxt.heat_level       = cfg_i.corrected_heat_level;
        end else begin
          nxt.heat_delay_count = hd_inc;
        end
      end

      if (trip1) begin
        nxt.stay_mode      = ModeOff;
        nxt.overrange_flag = 1'b1;
      end

      if (st_i.seconds_left != '0) begin
        nxt.seconds_left  = st_i.seconds_left - SecW'(1);
        nxt.protect_count = pc2;
        if (trip2) begin
          nxt.gap_mode       = ModeOff;
          nxt.overrange_flag = 1'b1;
        end
      end else if (cfg_i.timer_mode != '0) begin
        // Countdown expired in a timed mode: request power-off and drop
        // both protection modes.
        off               = 1'b1;
        nxt.seconds_left  = '0;
        nxt.protect_count = '0;
        nxt.gap_mode      = ModeOff;
        nxt.stay_mode     = ModeOff;
      end else begin
        nxt.protect_count = pc1;
      end
    end
  end

  assign st_o        = nxt;
  assign power_off_o = off;
endmodule

### src/sleep_timer_with_heat_protection_core.sv
// ----------------------------------------------------------------------------
// sleep_timer_with_heat_protection_core: sleep timer with heat protection
// Two-stage valid/ready pipeline around the next-state logic of the timer.
//
//   channel  dir  handshake         payload
//   in_i     in   valid/ready       func, device_on, seconds_value, modes, flags
//   out_o    out  valid/ready       power_off, overrange, heat, seconds, modes
//   cfg      in   cfg_we_i only     cfg_idx_i, cfg_data_i
//
// Each item is held in the input register, where the state update is
// computed, and then sits in the result register until it is taken.
// One item per cycle is sustained while the output is ready.
// The input stage keeps accepting while a result waits, up to one item deep.
// Reset clears the state, the configuration and both valid flags.
// ----------------------------------------------------------------------------
module sleep_timer_with_heat_protection_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  stwhp_in_if.sink                       in_i,
  stwhp_out_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [stwhp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stwhp_pkg::CfgDataW-1:0] cfg_data_i
);
  import stwhp_pkg::*;

  cfg_t      cfg;
  state_t    st_q, st_d;
  in_item_t  in_item;
  in_item_t  a_item_q;
  logic      a_valid_q, a_valid_d;
  out_item_t b_item_q, b_item_d;
  logic      b_valid_q, b_valid_d;
  logic      b_free, a_move, in_fire;
  logic      step_off;

  stwhp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  stwhp_step u_step (
    .st_i        (st_q),
    .cfg_i       (cfg),
    .item_i      (a_item_q),
    .st_o        (st_d),
    .power_off_o (step_off)
  );

  assign in_item.func            = in_i.func;
  assign in_item.device_on       = in_i.device_on;
  assign in_item.seconds_value   = in_i.seconds_value;
  assign in_item.stay_mode_in    = in_i.stay_mode_in;
  assign in_item.gap_mode_in     = in_i.gap_mode_in;
  assign in_item.heat_start_in   = in_i.heat_start_in;
  assign in_item.clear_overrange = in_i.clear_overrange;

  assign b_free     = !b_valid_q || out_o.ready;
  assign a_move     = a_valid_q && b_free;
  assign in_i.ready = !a_valid_q || b_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign a_valid_d = in_fire || (a_valid_q && !b_free);
  assign b_valid_d = a_move || (b_valid_q && !out_o.ready);

  assign b_item_d.power_off     = step_off;
  assign b_item_d.overrange     = st_d.overrange_flag;
  assign b_item_d.heat_level    = st_d.heat_level;
  assign b_item_d.seconds_left  = st_d.seconds_left;
  assign b_item_d.stay_mode_out = st_d.stay_mode;
  assign b_item_d.gap_mode_out  = st_d.gap_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      st_q      <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      if (a_move) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_item;
    end
    if (a_move) begin
      b_item_q <= b_item_d;
    end
  end

  assign out_o.valid         = b_valid_q;
  assign out_o.power_off     = b_item_q.power_off;
  assign out_o.overrange     = b_item_q.overrange;
  assign out_o.heat_level    = b_item_q.heat_level;
  assign out_o.seconds_left  = b_item_q.seconds_left;
  assign out_o.stay_mode_out = b_item_q.stay_mode_out;
  assign out_o.gap_mode_out  = b_item_q.gap_mode_out;

`ifndef SYNTHESIS
  // A power-off result always reports an empty countdown with both modes off.
  a_off_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.power_off |->
      out_o.seconds_left == '0 && out_o.stay_mode_out == ModeOff &&
      out_o.gap_mode_out == ModeOff)
    else $error("power-off result with nonzero countdown or active mode");

  // The prescaler never holds a full second.
  a_tick_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.tick_count < TickW'(TICKS_PER_SECOND))
    else $error("prescaler out of range");

  // An accepted item always lands in the input stage.
  a_accept_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> a_valid_q)
    else $error("accepted item lost");

  // The state only changes when an item leaves the input stage.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_move |=> $stable(st_q))
    else $error("state changed without an item");
`endif
endmodule
